// ----- hw/rtl/ptq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared codes and types of the packet transmit queue with interframe gap.
// ----------------------------------------------------------------------------
package ptq_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH     = 3'd0,
        MODE_REFRESH  = 3'd1,
        MODE_TICK     = 3'd2,
        MODE_REQUEST  = 3'd3,
        MODE_COMPLETE = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_FULL    = 3'd1,
        STATUS_LEN_ERR = 3'd2,
        STATUS_BUSY    = 3'd3,
        STATUS_NO_DATA = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } state_t;

    localparam logic REG_GAP_TICKS  = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    localparam int CFG_DATA_W   = 16;
    localparam int MAX_LENGTH_W = 9;
    localparam int TICK_W       = 16;
    localparam logic [8:0] MAX_LENGTH_RESET = 9'd150;
    localparam logic [15:0] GAP_TICKS_RESET = 16'd5;

    typedef struct packed {
        status_t    status;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       tx_valid;
    } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ptq_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_in_if
// Input channel: one push byte, refresh, tick, byte request or completion.
// ----------------------------------------------------------------------------
interface ptq_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output mode, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input mode, input data_byte, input last_byte,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ptq_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_out_if
// Result channel: status and, for byte requests, one byte of the packet.
// ----------------------------------------------------------------------------
interface ptq_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_valid;

    modport source (output valid, output status, output tx_byte, output tx_last,
                    output tx_valid, input ready);
    modport sink (input valid, input status, input tx_byte, input tx_last,
                  input tx_valid, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/packet_tx_queue_with_gap_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// packet_tx_queue_with_gap_top
// Transmit packet queue for one channel with a minimum gap between packets.
//
// The req channel carries one item per transfer: a packet byte push, a
// refresh, a tick, a byte request or a send completion. Results leave on the
// rsp channel: one for a push with the last mark, a refresh or a byte request.
// Items with a result pass through the result state: the packet store and
// the length table are RAMs with registered read data, and the result is
// formed from them there and loaded into the output register, while req is
// not ready. The output register holds one result; while it is full and not
// being taken, req is not ready. Configuration writes on cfg_wr_en take
// effect at the next edge. Reset empties the queue, clears the gap timer and
// the sender and loads the register defaults; the RAM contents are not
// cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module packet_tx_queue_with_gap_top #(
    parameter int QUEUE_DEPTH  = 32,
    parameter int PACKET_BYTES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ptq_in_if.sink                               req,
    ptq_out_if.source                            rsp,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [ptq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic             out_free;
    logic             res_valid;
    ptq_pkg::result_t res;

    ptq_ctrl #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptq_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_valid),
        .res   (res),
        .free  (out_free),
        .rsp   (rsp)
    );

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result loaded while output register still holds a result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.mode == ptq_pkg::MODE_REFRESH
                                    || req.mode == ptq_pkg::MODE_REQUEST))
        |=> res_valid)
        else $error("refresh or byte request produced no result");

    a_no_accept_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req.ready)
        else $error("input accepted while a result is being formed");

    a_byte_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.tx_valid) |-> (res.status == ptq_pkg::STATUS_OK))
        else $error("packet byte delivered with a status other than ok");

endmodule
`default_nettype wire

// ----- hw/rtl/ptq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ptq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_ctrl
// Queue control: staging of pushed packets, slot ring, gap timer and the
// sender, with the packet store and the length table in RAM.
// ----------------------------------------------------------------------------
module ptq_ctrl #(
    parameter int QUEUE_DEPTH  = 32,
    parameter int PACKET_BYTES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ptq_in_if.sink                               req,
    input  wire logic                            out_free,
    output logic                                 res_valid,
    output ptq_pkg::result_t                     res,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [ptq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOTS       = QUEUE_DEPTH + 1;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W       = $clog2(PACKET_BYTES + 1);
    localparam int STORE_DEPTH = SLOTS * PACKET_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    ptq_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SLOT_W-1:0] send_slot_reg, send_slot_next;
    logic [CNT_W-1:0]  queued_reg, queued_next;
    logic [LEN_W-1:0]  stg_cnt_reg, stg_cnt_next;
    logic [LEN_W-1:0]  send_idx_reg, send_idx_next;
    logic [LEN_W-1:0]  send_len_reg, send_len_next;
    logic              stg_ovf_reg, stg_ovf_next;
    logic              stg_blk_reg, stg_blk_next;
    logic              busy_reg, busy_next;
    logic [ptq_pkg::TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [ptq_pkg::TICK_W-1:0] gap_reg, gap_next;
    logic [ptq_pkg::MAX_LENGTH_W-1:0] maxlen_reg, maxlen_next;

    ptq_pkg::status_t pend_status_reg, pend_status_next;
    logic             pend_last_reg, pend_last_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_len_reg, pend_len_next;

    logic                 accept;
    logic                 in_ready;
    logic [ptq_pkg::MAX_LENGTH_W-1:0] lim;
    logic                 st_we;
    logic [STORE_AW-1:0]  st_waddr;
    logic                 st_re;
    logic [STORE_AW-1:0]  st_raddr;
    logic [7:0]           st_rdata;
    logic                 len_we;
    logic [LEN_W-1:0]     len_wdata;
    logic                 len_re;
    logic [LEN_W-1:0]     len_rdata;

    ptq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (req.data_byte),
        .rd_en   (st_re),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    ptq_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_len (
        .clk     (clk),
        .wr_en   (len_we),
        .wr_addr (tail_reg),
        .wr_data (len_wdata),
        .rd_en   (len_re),
        .rd_addr (head_reg),
        .rd_data (len_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptq_pkg::ST_IDLE:
            begin
                if (accept && ((req.mode == ptq_pkg::MODE_PUSH && req.last_byte)
                               || req.mode == ptq_pkg::MODE_REFRESH
                               || req.mode == ptq_pkg::MODE_REQUEST))
                begin
                    state_next = ptq_pkg::ST_RESULT;
                end
            end
            ptq_pkg::ST_RESULT:
            begin
                state_next = ptq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ptq_pkg::ST_IDLE:   in_ready  = out_free;
            ptq_pkg::ST_RESULT: res_valid = 1'b1;
            default:            in_ready  = 1'b0;
        endcase
        res.status   = pend_status_reg;
        res.tx_byte  = pend_valid_reg ? st_rdata : 8'd0;
        res.tx_last  = pend_last_reg;
        res.tx_valid = pend_valid_reg;
    end

    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;
    assign lim = (maxlen_reg < ptq_pkg::MAX_LENGTH_W'(PACKET_BYTES))
               ? maxlen_reg : ptq_pkg::MAX_LENGTH_W'(PACKET_BYTES);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        send_slot_next   = send_slot_reg;
        queued_next      = queued_reg;
        stg_cnt_next     = stg_cnt_reg;
        send_idx_next    = send_idx_reg;
        send_len_next    = send_len_reg;
        stg_ovf_next     = stg_ovf_reg;
        stg_blk_next     = stg_blk_reg;
        busy_next        = busy_reg;
        elapsed_next     = elapsed_reg;
        gap_next         = gap_reg;
        maxlen_next      = maxlen_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        pend_valid_next  = pend_valid_reg;
        pend_len_next    = pend_len_reg;
        st_we     = 1'b0;
        st_waddr  = STORE_AW'(tail_reg) * STORE_AW'(PACKET_BYTES) + STORE_AW'(stg_cnt_reg);
        st_re     = 1'b0;
        st_raddr  = STORE_AW'(send_slot_reg) * STORE_AW'(PACKET_BYTES)
                  + STORE_AW'(send_idx_reg);
        len_we    = 1'b0;
        len_re    = 1'b0;
        len_wdata = stg_cnt_reg;

        if (cfg_wr_en)
        begin
            if (cfg_index == ptq_pkg::REG_GAP_TICKS)
            begin
                gap_next = cfg_data;
            end
            else
            begin
                maxlen_next = cfg_data[ptq_pkg::MAX_LENGTH_W-1:0];
            end
        end

        if (state_reg == ptq_pkg::ST_RESULT && pend_len_reg)
        begin
            send_len_next = len_rdata;
            pend_len_next = 1'b0;
        end

        if (accept)
        begin
            pend_status_next = ptq_pkg::STATUS_NO_DATA;
            pend_last_next   = 1'b0;
            pend_valid_next  = 1'b0;
            pend_len_next    = 1'b0;
            unique case (req.mode)
                ptq_pkg::MODE_PUSH:
                begin
                    if (ptq_pkg::MAX_LENGTH_W'(stg_cnt_reg) >= lim)
                    begin
                        stg_ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (busy_reg && tail_reg == send_slot_reg)
                        begin
                            stg_blk_next = 1'b1;
                        end
                        else
                        begin
                            st_we = 1'b1;
                        end
                        stg_cnt_next = stg_cnt_reg + LEN_W'(1);
                    end
                    len_wdata = stg_cnt_next;
                    if (req.last_byte)
                    begin
                        if (queued_reg >= CNT_W'(QUEUE_DEPTH) || stg_blk_next)
                        begin
                            pend_status_next = ptq_pkg::STATUS_FULL;
                        end
                        else if (stg_ovf_next)
                        begin
                            pend_status_next = ptq_pkg::STATUS_LEN_ERR;
                        end
                        else
                        begin
                            len_we           = 1'b1;
                            tail_next        = (tail_reg == SLOT_W'(SLOTS - 1))
                                             ? '0 : tail_reg + SLOT_W'(1);
                            queued_next      = queued_reg + CNT_W'(1);
                            pend_status_next = ptq_pkg::STATUS_OK;
                        end
                        stg_cnt_next = '0;
                        stg_ovf_next = 1'b0;
                        stg_blk_next = 1'b0;
                    end
                end
                ptq_pkg::MODE_REFRESH:
                begin
                    if (busy_reg)
                    begin
                        pend_status_next = ptq_pkg::STATUS_BUSY;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        if (elapsed_reg <= gap_reg)
                        begin
                            pend_status_next = ptq_pkg::STATUS_BUSY;
                        end
                        else if (queued_reg != '0)
                        begin
                            len_re           = 1'b1;
                            pend_len_next    = 1'b1;
                            send_slot_next   = head_reg;
                            send_idx_next    = '0;
                            head_next        = (head_reg == SLOT_W'(SLOTS - 1))
                                             ? '0 : head_reg + SLOT_W'(1);
                            queued_next      = queued_reg - CNT_W'(1);
                            busy_next        = 1'b1;
                            pend_status_next = ptq_pkg::STATUS_OK;
                        end
                    end
                end
                ptq_pkg::MODE_TICK:
                begin
                    if (elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + ptq_pkg::TICK_W'(1);
                    end
                end
                ptq_pkg::MODE_REQUEST:
                begin
                    if (busy_reg && send_idx_reg < send_len_reg)
                    begin
                        st_re            = 1'b1;
                        pend_valid_next  = 1'b1;
                        pend_last_next   = (send_idx_reg + LEN_W'(1) == send_len_reg);
                        pend_status_next = ptq_pkg::STATUS_OK;
                        send_idx_next    = send_idx_reg + LEN_W'(1);
                    end
                end
                ptq_pkg::MODE_COMPLETE:
                begin
                    busy_next    = 1'b0;
                    elapsed_next = '0;
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ptq_pkg::ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            send_slot_reg   <= '0;
            queued_reg      <= '0;
            stg_cnt_reg     <= '0;
            send_idx_reg    <= '0;
            send_len_reg    <= '0;
            stg_ovf_reg     <= 1'b0;
            stg_blk_reg     <= 1'b0;
            busy_reg        <= 1'b0;
            elapsed_reg     <= '0;
            gap_reg         <= ptq_pkg::GAP_TICKS_RESET;
            maxlen_reg      <= ptq_pkg::MAX_LENGTH_RESET;
            pend_status_reg <= ptq_pkg::STATUS_OK;
            pend_last_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_len_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            send_slot_reg   <= send_slot_next;
            queued_reg      <= queued_next;
            stg_cnt_reg     <= stg_cnt_next;
            send_idx_reg    <= send_idx_next;
            send_len_reg    <= send_len_next;
            stg_ovf_reg     <= stg_ovf_next;
            stg_blk_reg     <= stg_blk_next;
            busy_reg        <= busy_next;
            elapsed_reg     <= elapsed_next;
            gap_reg         <= gap_next;
            maxlen_reg      <= maxlen_next;
            pend_status_reg <= pend_status_next;
            pend_last_reg   <= pend_last_next;
            pend_valid_reg  <= pend_valid_next;
            pend_len_reg    <= pend_len_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ptq_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_out_stage
// Output register that holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module ptq_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ptq_pkg::result_t res,
    output logic                  free,
    ptq_out_if.source             rsp
);

    logic             valid_reg, valid_next;
    ptq_pkg::result_t data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign free         = !valid_reg || rsp.ready;
    assign rsp.valid    = valid_reg;
    assign rsp.status   = data_reg.status;
    assign rsp.tx_byte  = data_reg.tx_byte;
    assign rsp.tx_last  = data_reg.tx_last;
    assign rsp.tx_valid = data_reg.tx_valid;

endmodule
`default_nettype wire
